>>> hw/rtl/modbus_holding_register_responder_macros.svh
// assertion macros used by the responder rtl
`ifndef MODBUS_HOLDING_REGISTER_RESPONDER_MACROS_SVH
`define MODBUS_HOLDING_REGISTER_RESPONDER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("responder check failed");

// antecedent implies consequent in the next cycle
`define MHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("responder check failed");

`endif

>>> hw/rtl/mhr_pkg.sv
// types and constants of the holding register responder
`timescale 1ns / 1ps

package mhr_pkg;

    // default sizing
    localparam int DEF_REGISTER_DEPTH = 1024;
    localparam int DEF_MAX_READ_WORDS = 27;

    // frame layout
    localparam int         HDR_BYTES   = 12;
    localparam logic [9:0] POS_MAX     = 10'd1023;
    localparam logic [9:0] MIN_FRAME   = 10'd8;
    localparam logic [9:0] DATA_START  = 10'd13;
    localparam logic [3:0] IDX_LEN_HI  = 4'd4;
    localparam logic [3:0] IDX_LEN_LO  = 4'd5;
    localparam logic [3:0] IDX_UNIT    = 4'd6;
    localparam logic [3:0] IDX_FUNC    = 4'd7;
    localparam logic [3:0] IDX_BCOUNT  = 4'd8;
    localparam logic [3:0] IDX_ECHO_END = 4'd11;
    localparam logic [7:0] LEN_SIX     = 8'd6;
    localparam logic [15:0] LEN_BASE   = 16'd3;

    // register preset: entry i holds i*10+1
    localparam logic [15:0] INIT_BASE  = 16'd1;
    localparam logic [15:0] INIT_STEP  = 16'd10;

    // function codes
    localparam logic [7:0] FC_READ    = 8'd3;
    localparam logic [7:0] FC_WRITE1  = 8'd6;
    localparam logic [7:0] FC_WRITEN  = 8'd16;

    // response status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_ERR,
        S_RD_HDR,
        S_RD_HI,
        S_RD_LO,
        S_ECHO
    } t_state;

endpackage

>>> hw/rtl/mhr_if.sv
// request and response stream interfaces
`timescale 1ns / 1ps

interface mhr_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface mhr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_byte;

    modport source (output valid, output out_byte, output status, output last_byte,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_byte,
                    output ready);
endinterface

>>> hw/rtl/modbus_holding_register_responder.sv
// modbus tcp holding register responder, top level
// i_req carries request frame bytes in wire order, frame_last on the final beat.
// o_rsp carries response bytes, last_byte on the final beat of each response,
// status nonzero on a single error beat (count above cap, range outside memory).
// Request beats are taken one per cycle while idle, with no response in progress.
// After the final request beat a decode state evaluates the frame, then response
// beats leave at one per cycle while the receiver is ready: 9 header beats plus
// 2N word beats for a read, 12 beats for a write echo, one beat for an error. Read
// words come from the register memory with a registered read that is issued one
// beat ahead. Request beats are not taken while a response is generated.
// After reset the memory is preset by a pass over all REGISTER_DEPTH entries, one
// entry a cycle, during which no request beat is taken.
// A stalled receiver holds the output register; the sequencer waits with it,
// and the next request beat is taken while the final response beat waits.
`timescale 1ns / 1ps
`include "modbus_holding_register_responder_macros.svh"

module modbus_holding_register_responder #(
    parameter int REGISTER_DEPTH = mhr_pkg::DEF_REGISTER_DEPTH,
    parameter int MAX_READ_WORDS = mhr_pkg::DEF_MAX_READ_WORDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mhr_req_if.sink        i_req,
    mhr_rsp_if.source      o_rsp
);
    import mhr_pkg::*;

    localparam int          AW      = (REGISTER_DEPTH > 1) ? $clog2(REGISTER_DEPTH) : 1;
    localparam int          CW      = $clog2(MAX_READ_WORDS + 1);
    localparam logic [16:0] DEPTH_W = 17'(REGISTER_DEPTH);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(REGISTER_DEPTH - 1);

    // register memory
    logic [15:0]    r_mem [REGISTER_DEPTH];
    logic [15:0]    r_rd_q;
    logic           rd_en;
    logic [CW-1:0]  rd_word;
    logic [16:0]    rd_addr_w;
    logic           w_en;
    logic [16:0]    w_addr_w;
    logic [15:0]    w_data;

    // frame capture
    logic [7:0]     r_hdr [HDR_BYTES];
    logic [3:0]     r_hdr_cnt;
    logic [9:0]     r_pos;
    logic [9:0]     r_cursor;
    logic [7:0]     r_pending;
    logic           acc;
    logic [9:0]     fp_new;

    // sequencer
    t_state         r_state, n_state;
    logic [3:0]     r_idx, n_idx;
    logic [CW-1:0]  r_word, n_word;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]  r_addr, n_addr;
    logic           r_len6, n_len6;
    t_status        r_err, n_err;
    logic [AW-1:0]  r_init_addr;
    logic [15:0]    r_init_val;

    // output register
    logic           r_ovld;
    logic [7:0]     r_obyte;
    t_status        r_ostat;
    logic           r_olast;
    logic           can_emit;
    logic           em_valid;
    logic [7:0]     em_byte;
    t_status        em_status;
    logic           em_last;

    // masked header and decoded fields
    logic [7:0]     hm [HDR_BYTES];
    logic [15:0]    e_addr, e_cnt;
    logic [16:0]    e_sum;
    logic [15:0]    d_start, d_cnt;
    logic [16:0]    d_sum;
    logic [15:0]    rd_len;
    logic           word_last;

    assign acc       = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign can_emit  = !r_ovld || o_rsp.ready;
    assign fp_new    = (r_pos != POS_MAX) ? r_pos + 10'd1 : r_pos;

    // header bytes not received in this frame read as zero
    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            hm[k] = (4'(k) < r_hdr_cnt) ? r_hdr[k] : 8'd0;
        end
    end

    assign e_addr  = {hm[8], hm[9]};
    assign e_cnt   = {hm[10], hm[11]};
    assign e_sum   = {1'b0, e_addr} + {1'b0, e_cnt};
    assign d_start = {r_hdr[8], r_hdr[9]};
    assign d_cnt   = {r_hdr[10], r_hdr[11]};
    assign d_sum   = {1'b0, d_start} + {1'b0, d_cnt};
    assign rd_len  = LEN_BASE + 16'({r_cnt, 1'b0});
    assign word_last = (({1'b0, r_word} + (CW + 1)'(1)) == {1'b0, r_cnt});
    assign rd_addr_w = 17'(r_addr) + 17'(rd_word);

    // frame position, write cursor and header capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_cursor  <= '0;
            r_pending <= '0;
        end else if (acc) begin
            // header bytes are kept on the closing beat too
            if (r_pos < 10'(HDR_BYTES)) begin
                r_hdr[r_pos[3:0]] <= i_req.data_byte;
            end
            if (i_req.frame_last) begin
                r_pos     <= '0;
                r_cursor  <= '0;
                r_pending <= '0;
                r_hdr_cnt <= (fp_new >= 10'(HDR_BYTES)) ? 4'(HDR_BYTES) : fp_new[3:0];
            end else if (r_pos != POS_MAX) begin
                if (r_pos >= DATA_START && r_hdr[IDX_FUNC] == FC_WRITEN) begin
                    if (r_pos[0]) begin
                        r_pending <= i_req.data_byte;
                    end else begin
                        r_cursor <= r_cursor + 10'd1;
                    end
                end
                r_pos <= r_pos + 10'd1;
            end
        end
    end

    // sequencer state and context registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
        r_idx  <= n_idx;
        r_word <= n_word;
        r_cnt  <= n_cnt;
        r_addr <= n_addr;
        r_len6 <= n_len6;
        r_err  <= n_err;
    end

    // preset pass counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_addr <= '0;
            r_init_val  <= INIT_BASE;
        end else if (r_state == S_INIT) begin
            r_init_addr <= r_init_addr + AW'(1);
            r_init_val  <= r_init_val + INIT_STEP;
        end
    end

    // next state, memory access and response beats
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_word    = r_word;
        n_cnt     = r_cnt;
        n_addr    = r_addr;
        n_len6    = r_len6;
        n_err     = r_err;
        em_valid  = 1'b0;
        em_byte   = 8'd0;
        em_status = ST_OK;
        em_last   = 1'b0;
        rd_en     = 1'b0;
        rd_word   = '0;
        w_en      = 1'b0;
        w_addr_w  = '0;
        w_data    = '0;
        unique case (r_state)
            S_INIT: begin
                w_en     = 1'b1;
                w_addr_w = 17'(r_init_addr);
                w_data   = r_init_val;
                if (r_init_addr == LAST_ENTRY) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // function 16 data word completes on its low byte
                if (acc && r_pos != POS_MAX && r_pos >= DATA_START && !r_pos[0]
                        && r_hdr[IDX_FUNC] == FC_WRITEN
                        && {6'd0, r_cursor} < d_cnt && d_sum <= DEPTH_W) begin
                    w_en     = 1'b1;
                    w_addr_w = {1'b0, d_start} + 17'(r_cursor);
                    w_data   = {r_pending, i_req.data_byte};
                end
                if (acc && i_req.frame_last && fp_new > MIN_FRAME) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_idx  = '0;
                n_word = '0;
                n_cnt  = CW'(e_cnt);
                n_addr = AW'(e_addr);
                n_len6 = 1'b0;
                priority if (hm[IDX_FUNC] == FC_READ) begin
                    if (e_cnt > 16'(MAX_READ_WORDS)) begin
                        n_err   = ST_COUNT;
                        n_state = S_ERR;
                    end else if (e_sum > DEPTH_W) begin
                        n_err   = ST_RANGE;
                        n_state = S_ERR;
                    end else begin
                        n_state = S_RD_HDR;
                    end
                end else if (hm[IDX_FUNC] == FC_WRITE1) begin
                    if ({1'b0, e_addr} >= DEPTH_W) begin
                        n_err   = ST_RANGE;
                        n_state = S_ERR;
                    end else begin
                        w_en     = 1'b1;
                        w_addr_w = {1'b0, e_addr};
                        w_data   = e_cnt;
                        n_state  = S_ECHO;
                    end
                end else if (hm[IDX_FUNC] == FC_WRITEN) begin
                    if (e_sum > DEPTH_W) begin
                        n_err   = ST_RANGE;
                        n_state = S_ERR;
                    end else begin
                        n_len6  = 1'b1;
                        n_state = S_ECHO;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                em_valid  = 1'b1;
                em_status = r_err;
                em_last   = 1'b1;
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_HDR: begin
                em_valid = 1'b1;
                unique case (r_idx)
                    IDX_LEN_HI: em_byte = rd_len[15:8];
                    IDX_LEN_LO: em_byte = rd_len[7:0];
                    IDX_UNIT:   em_byte = hm[IDX_UNIT];
                    IDX_FUNC:   em_byte = hm[IDX_FUNC];
                    IDX_BCOUNT: em_byte = 8'({r_cnt, 1'b0});
                    default:    em_byte = hm[r_idx];
                endcase
                em_last = (r_idx == IDX_BCOUNT) && (r_cnt == '0);
                if (can_emit) begin
                    if (r_idx == IDX_BCOUNT) begin
                        if (r_cnt == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            // fetch the first word one beat ahead
                            rd_en   = 1'b1;
                            rd_word = '0;
                            n_state = S_RD_HI;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_RD_HI: begin
                em_valid = 1'b1;
                em_byte  = r_rd_q[15:8];
                if (can_emit) begin
                    n_state = S_RD_LO;
                end
            end
            S_RD_LO: begin
                em_valid = 1'b1;
                em_byte  = r_rd_q[7:0];
                em_last  = word_last;
                if (can_emit) begin
                    if (word_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_word  = r_word + CW'(1);
                        rd_en   = 1'b1;
                        rd_word = r_word + CW'(1);
                        n_state = S_RD_HI;
                    end
                end
            end
            S_ECHO: begin
                em_valid = 1'b1;
                if (r_len6 && r_idx == IDX_LEN_HI) begin
                    em_byte = 8'd0;
                end else if (r_len6 && r_idx == IDX_LEN_LO) begin
                    em_byte = LEN_SIX;
                end else begin
                    em_byte = hm[r_idx];
                end
                em_last = (r_idx == IDX_ECHO_END);
                if (can_emit) begin
                    if (r_idx == IDX_ECHO_END) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr_w[AW-1:0]] <= w_data;
        end
    end

    // memory read port, registered data
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q <= r_mem[rd_addr_w[AW-1:0]];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (can_emit) begin
            r_ovld <= em_valid;
        end
        if (can_emit && em_valid) begin
            r_obyte <= em_byte;
            r_ostat <= em_status;
            r_olast <= em_last;
        end
    end

    assign o_rsp.valid     = r_ovld;
    assign o_rsp.out_byte  = r_obyte;
    assign o_rsp.status    = r_ostat;
    assign o_rsp.last_byte = r_olast;

    // checks
    `MHR_ASSERT_IMP(a_rd_in_range, i_clk, i_rst_n, rd_en, rd_addr_w < DEPTH_W)
    `MHR_ASSERT_IMP(a_wr_in_range, i_clk, i_rst_n, w_en, w_addr_w < DEPTH_W)
    `MHR_ASSERT_IMP(a_err_beat_alone, i_clk, i_rst_n, r_ovld && r_ostat != ST_OK,
                    r_olast && r_obyte == 8'd0)
    `MHR_ASSERT_NXT(a_eval_after_end, i_clk, i_rst_n,
                    r_state == S_IDLE && !(acc && i_req.frame_last), r_state != S_EVAL)

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// testbench of the holding register responder: random request frames checked beat by beat

module tb;
    import mhr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int REG_DEPTH     = DEF_REGISTER_DEPTH;
    localparam int READ_CAP      = DEF_MAX_READ_WORDS;
    // preset pass after reset plus the longest gap and stall, several times over
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_BYTES  = 85;
    localparam int SETTLE_CYCLES = 30;
    localparam int ADDR_POS      = 8;
    localparam int COUNT_POS     = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_req_beat;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_rsp_beat;

    typedef enum int {
        K_READ,
        K_WRITE1,
        K_WRITEN,
        K_CAP,
        K_RANGE,
        K_OTHER,
        K_SHORT,
        K_TRUNC
    } t_frame_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mhr_req_if req_bus ();
    mhr_rsp_if rsp_bus ();

    modbus_holding_register_responder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // responder state as predicted
    logic [15:0] holding_regs [REG_DEPTH];
    logic [7:0]  frame_hdr [HDR_BYTES];
    logic [9:0]  frame_pos;
    logic [7:0]  word_hi;
    logic [9:0]  word_idx;

    t_req_beat   request_beats [$];
    t_rsp_beat   expected_rsp_beats [$];
    logic [7:0]  frame_bytes [$];
    t_rsp_beat   want_beat;

    int error_count = 0;
    int send_gap    = 0;
    int send_calm   = 0;
    int stall_left  = 0;
    int recv_calm   = 0;
    int idle_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic logic [7:0] hdr_at(input int k);
        if (k < HDR_BYTES && k < int'(frame_pos)) return frame_hdr[k];
        return 8'd0;
    endfunction

    function automatic logic [15:0] hdr_word_at(input int k);
        return {hdr_at(k), hdr_at(k + 1)};
    endfunction

    task automatic push_rsp(input logic [7:0] data, input t_status st, input logic last);
        t_rsp_beat beat;
        beat.data   = data;
        beat.status = st;
        beat.last   = last;
        expected_rsp_beats.push_back(beat);
    endtask

    // write echo, length field forced to six for multi-register writes
    task automatic echo_request(input logic len_six);
        logic [7:0] b;
        for (int k = 0; k < HDR_BYTES; k++) begin
            b = hdr_at(k);
            if (len_six && k == IDX_LEN_HI) b = 8'd0;
            if (len_six && k == IDX_LEN_LO) b = LEN_SIX;
            push_rsp(b, ST_OK, k == IDX_ECHO_END);
        end
    endtask

    task automatic answer_frame();
        logic [7:0]  func;
        int          addr;
        int          cnt;
        logic [15:0] len;
        logic [15:0] w;
        func = hdr_at(IDX_FUNC);
        addr = hdr_word_at(ADDR_POS);
        cnt  = hdr_word_at(COUNT_POS);
        if (func == FC_READ) begin
            if (cnt > READ_CAP) begin
                push_rsp(8'd0, ST_COUNT, 1'b1);
            end else if (addr + cnt > REG_DEPTH) begin
                push_rsp(8'd0, ST_RANGE, 1'b1);
            end else begin
                len = LEN_BASE + 16'(2 * cnt);
                for (int k = 0; k < 4; k++) push_rsp(hdr_at(k), ST_OK, 1'b0);
                push_rsp(len[15:8], ST_OK, 1'b0);
                push_rsp(len[7:0], ST_OK, 1'b0);
                push_rsp(hdr_at(IDX_UNIT), ST_OK, 1'b0);
                push_rsp(func, ST_OK, 1'b0);
                push_rsp(8'(2 * cnt), ST_OK, cnt == 0);
                for (int k = 0; k < cnt; k++) begin
                    w = holding_regs[addr + k];
                    push_rsp(w[15:8], ST_OK, 1'b0);
                    push_rsp(w[7:0], ST_OK, k + 1 == cnt);
                end
            end
        end else if (func == FC_WRITE1) begin
            if (addr >= REG_DEPTH) begin
                push_rsp(8'd0, ST_RANGE, 1'b1);
            end else begin
                holding_regs[addr] = 16'(cnt);
                echo_request(1'b0);
            end
        end else if (func == FC_WRITEN) begin
            if (addr + cnt > REG_DEPTH) push_rsp(8'd0, ST_RANGE, 1'b1);
            else echo_request(1'b1);
        end
    endtask

    // one accepted request beat
    task automatic take_request_byte(input logic [7:0] b, input logic is_last);
        int start;
        int cnt;
        if (frame_pos < POS_MAX) begin
            if (frame_pos < HDR_BYTES) begin
                frame_hdr[frame_pos] = b;
            end else if (frame_pos >= DATA_START && hdr_at(IDX_FUNC) == FC_WRITEN) begin
                if (((frame_pos - DATA_START) & 10'd1) == 10'd0) begin
                    word_hi = b;
                end else begin
                    start = hdr_word_at(ADDR_POS);
                    cnt   = hdr_word_at(COUNT_POS);
                    if (int'(word_idx) < cnt && start + cnt <= REG_DEPTH)
                        holding_regs[start + int'(word_idx)] = {word_hi, b};
                    word_idx = word_idx + 10'd1;
                end
            end
            frame_pos = frame_pos + 10'd1;
        end
        if (is_last) begin
            if (frame_pos > MIN_FRAME) answer_frame();
            frame_pos = '0;
            word_idx  = '0;
            word_hi   = '0;
        end
    endtask

    // ---------------------------------------------------------------- frame building

    task automatic add_noise(input int n);
        for (int k = 0; k < n; k++) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic fit_length(input int n);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
        add_noise(n - frame_bytes.size());
    endtask

    // random mbap header, then function, address and count or value
    task automatic start_frame(input logic [7:0] func, input logic [15:0] addr,
                               input logic [15:0] val);
        frame_bytes.delete();
        add_noise(IDX_FUNC);
        frame_bytes.push_back(func);
        frame_bytes.push_back(addr[15:8]);
        frame_bytes.push_back(addr[7:0]);
        frame_bytes.push_back(val[15:8]);
        frame_bytes.push_back(val[7:0]);
    endtask

    task automatic send_frame();
        t_req_beat beat;
        foreach (frame_bytes[k]) begin
            beat.data = frame_bytes[k];
            beat.last = (k == frame_bytes.size() - 1);
            request_beats.push_back(beat);
        end
    endtask

    // mostly a small window so that reads see earlier writes, sometimes the top
    function automatic int pick_addr(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 47);
        if (r < 8) return REG_DEPTH - span;
        return $urandom_range(0, REG_DEPTH - span);
    endfunction

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return K_READ;
        if (r < 42) return K_WRITE1;
        if (r < 62) return K_WRITEN;
        if (r < 70) return K_CAP;
        if (r < 78) return K_RANGE;
        if (r < 85) return K_OTHER;
        if (r < 92) return K_SHORT;
        return K_TRUNC;
    endfunction

    task automatic queue_frame(input t_frame_kind kind);
        int          cnt;
        int          addr;
        int          words;
        int          r;
        logic [7:0]  func;
        case (kind)
            K_READ: begin
                r = $urandom_range(0, 9);
                cnt = (r == 0) ? 0 : (r == 1) ? READ_CAP : $urandom_range(1, 6);
                start_frame(FC_READ, 16'(pick_addr(cnt)), 16'(cnt));
                if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 3));
            end
            K_WRITE1: begin
                start_frame(FC_WRITE1, 16'(pick_addr(1)), 16'($urandom));
                if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 3));
            end
            K_WRITEN: begin
                cnt = $urandom_range(0, 6);
                start_frame(FC_WRITEN, 16'(pick_addr(cnt)), 16'(cnt));
                // byte count, then data words: some missing, some extra
                words = cnt + $urandom_range(0, 3) - 1;
                if (words < 0) words = 0;
                add_noise(1 + 2 * words + (($urandom_range(0, 3) == 0) ? 1 : 0));
            end
            K_CAP: begin
                r = $urandom_range(0, 3);
                cnt = (r == 0) ? READ_CAP + 1 : (r == 1) ? 16'hFFFF
                      : $urandom_range(READ_CAP + 1, 16'hFFFF);
                start_frame(FC_READ, 16'($urandom), 16'(cnt));
            end
            K_RANGE: begin
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    cnt  = $urandom_range(0, READ_CAP);
                    addr = $urandom_range(REG_DEPTH + 1 - cnt,
                                          $urandom_range(0, 1) ? REG_DEPTH + 40 : 16'hFFFF);
                    start_frame(FC_READ, 16'(addr), 16'(cnt));
                end else if (r == 1) begin
                    addr = $urandom_range(0, 1) ? REG_DEPTH : $urandom_range(REG_DEPTH, 16'hFFFF);
                    start_frame(FC_WRITE1, 16'(addr), 16'($urandom));
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        cnt  = 16'hFFFF;
                        addr = $urandom_range(0, 16'hFFFF);
                    end else begin
                        cnt  = $urandom_range(1, 40);
                        addr = $urandom_range(REG_DEPTH + 1 - cnt, REG_DEPTH + 40);
                    end
                    start_frame(FC_WRITEN, 16'(addr), 16'(cnt));
                    add_noise(1 + 2 * $urandom_range(0, 4));
                end
            end
            K_OTHER: begin
                do func = 8'($urandom);
                while (func == FC_READ || func == FC_WRITE1 || func == FC_WRITEN);
                start_frame(func, 16'($urandom), 16'($urandom));
                fit_length($urandom_range(MIN_FRAME + 1, 18));
            end
            K_SHORT: begin
                frame_bytes.delete();
                add_noise($urandom_range(1, MIN_FRAME));
            end
            default: begin
                // truncated header, missing bytes read as zero
                r = $urandom_range(0, 2);
                func = (r == 0) ? FC_READ : (r == 1) ? FC_WRITE1 : FC_WRITEN;
                start_frame(func, 16'($urandom), 16'($urandom));
                fit_length($urandom_range(MIN_FRAME + 1, HDR_BYTES - 1));
            end
        endcase
        send_frame();
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic wait_idle();
        while (request_beats.size() != 0 || req_bus.valid || expected_rsp_beats.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- request driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid      <= 1'b0;
            req_bus.data_byte  <= '0;
            req_bus.frame_last <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                take_request_byte(req_bus.data_byte, req_bus.frame_last);
            if (!req_bus.valid || req_bus.ready) begin
                if (send_gap > 0) begin
                    req_bus.valid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end else if (request_beats.size() > 0) begin
                    req_bus.valid      <= 1'b1;
                    req_bus.data_byte  <= request_beats[0].data;
                    req_bus.frame_last <= request_beats[0].last;
                    void'(request_beats.pop_front());
                    // occasional stretch of back-to-back beats
                    if (send_calm > 0) begin
                        send_calm <= send_calm - 1;
                        send_gap  <= 0;
                    end else begin
                        send_calm <= ($urandom_range(0, 24) == 0) ? $urandom_range(10, 40) : 0;
                        send_gap  <= draw_gap();
                    end
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- response monitor

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsp_beats.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected response beat: byte %02h status %0d last %0b",
                             $time, rsp_bus.out_byte, rsp_bus.status, rsp_bus.last_byte);
                end else begin
                    want_beat = expected_rsp_beats.pop_front();
                    if (rsp_bus.out_byte !== want_beat.data) begin
                        error_count++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want_beat.data, rsp_bus.out_byte);
                    end
                    if (rsp_bus.status !== want_beat.status) begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want_beat.status, rsp_bus.status);
                    end
                    if (rsp_bus.last_byte !== want_beat.last) begin
                        error_count++;
                        $display("%0t: last_byte expected %0b actual %0b",
                                 $time, want_beat.last, rsp_bus.last_byte);
                    end
                end
            end
            // receiver stalls, with stretches of steady ready
            if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else if (recv_calm > 0) begin
                rsp_bus.ready <= 1'b1;
                recv_calm     <= recv_calm - 1;
            end else begin
                rsp_bus.ready <= 1'b1;
                stall_left    <= draw_gap();
                recv_calm     <= ($urandom_range(0, 24) == 0) ? $urandom_range(10, 40) : 0;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        t_frame_kind kind_order [$];
        t_frame_kind tmp_kind;
        int          j;
        int          random_bytes;

        req_bus.valid      = 1'b0;
        req_bus.data_byte  = '0;
        req_bus.frame_last = 1'b0;
        rsp_bus.ready      = 1'b0;
        i_rst_n            = 1'b0;

        for (int k = 0; k < REG_DEPTH; k++)
            holding_regs[k] = INIT_BASE + 16'(k) * INIT_STEP;
        foreach (frame_hdr[k]) frame_hdr[k] = '0;
        frame_pos = '0;
        word_hi   = '0;
        word_idx  = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // top register to all ones, then the largest read that ends on it
        start_frame(FC_WRITE1, 16'(REG_DEPTH - 1), 16'hFFFF);
        send_frame();
        start_frame(FC_READ, 16'(REG_DEPTH - READ_CAP), 16'(READ_CAP));
        send_frame();
        // single zero beat that closes a frame
        frame_bytes.delete();
        frame_bytes.push_back(8'h00);
        send_frame();

        // hold the sender until the responder has drained
        wait_idle();

        // each kind once in shuffled order, then weighted picks
        for (int k = K_READ; k <= K_TRUNC; k++) kind_order.push_back(t_frame_kind'(k));
        for (int k = kind_order.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp_kind      = kind_order[k];
            kind_order[k] = kind_order[j];
            kind_order[j] = tmp_kind;
        end
        random_bytes = 0;
        foreach (kind_order[k]) begin
            queue_frame(kind_order[k]);
            random_bytes += frame_bytes.size();
        end
        while (random_bytes < RANDOM_BYTES) begin
            queue_frame(pick_kind());
            random_bytes += frame_bytes.size();
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
